@@ rtl/block_median_peak_tracker_defines.svh @@
// assertion macros for the median peak tracker
`ifndef BLOCK_MEDIAN_PEAK_TRACKER_DEFINES_SVH
`define BLOCK_MEDIAN_PEAK_TRACKER_DEFINES_SVH

`ifndef SYNTH
// checked while out of reset
`define BMPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("block_median_peak_tracker: check failed");
// checked on every edge, reset included
`define BMPT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("block_median_peak_tracker: check failed");
`else
`define BMPT_ASSERT(lbl, prop)
`define BMPT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/bmpt_pkg.sv @@
`timescale 1ns / 1ps

package bmpt_pkg;

  // window length and sample width
  localparam int unsigned Window     = 7;
  localparam int unsigned SampleBits = 12;

  // derived sizes
  localparam int unsigned CntW   = $clog2(Window);
  localparam int unsigned MidIdx = Window / 2;

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [CntW-1:0]       cnt_t;

  // link from one sort cell to its right neighbor
  typedef struct packed {
    logic    ins;
    sample_t data;
  } link_t;

endpackage

@@ rtl/block_median_peak_tracker.sv @@
// result: the median of a window is registered and valid in the cycle after its seventh sample is taken
// throughput: one sample per cycle while results are drained; one result per seven samples
// a pending result that is not taken holds off further samples (single output register)
// the sorted window lives in a row of insertion cells, one sample slot each
// reset (async, active low): empty window, no result, peak high 0, peak low 4095
`timescale 1ns / 1ps
`include "block_median_peak_tracker_defines.svh"

module block_median_peak_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [11:0] sample_i,
  input  logic        sample_valid_i,
  output logic        sample_ready_o,
  output logic [11:0] median_o,
  output logic [11:0] peak_high_o,
  output logic [11:0] peak_low_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  bmpt_pkg::cnt_t    fill_cnt_q, fill_cnt_d;
  logic              accept;
  logic              last;
  logic              done;
  logic              space;
  bmpt_pkg::link_t   links [bmpt_pkg::Window+1];
  bmpt_pkg::sample_t cell_next [bmpt_pkg::Window];

  // request handshake
  assign sample_ready_o = space;
  assign accept         = sample_valid_i && sample_ready_o;
  assign last           = (fill_cnt_q == bmpt_pkg::cnt_t'(bmpt_pkg::Window - 1));
  assign done           = accept && last;

  // fill count of the current window
  always_comb begin
    fill_cnt_d = fill_cnt_q;
    if (accept) begin
      fill_cnt_d = last ? '0 : fill_cnt_q + bmpt_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q <= '0;
    end else begin
      fill_cnt_q <= fill_cnt_d;
    end
  end

  // insertion chain, ascending from cell 0
  assign links[0] = '{ins: 1'b0, data: '0};

  for (genvar i = 0; i < bmpt_pkg::Window; i++) begin : g_cell
    bmpt_sort_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (accept),
      .occupied_i (bmpt_pkg::cnt_t'(i) < fill_cnt_q),
      .sample_i   (sample_i),
      .left_i     (links[i]),
      .right_o    (links[i+1]),
      .next_o     (cell_next[i])
    );
  end

  // result register and running extremes
  bmpt_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .done_i      (done),
    .median_i    (cell_next[bmpt_pkg::MidIdx]),
    .out_ready_i (out_ready_i),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .median_o    (median_o),
    .peak_high_o (peak_high_o),
    .peak_low_o  (peak_low_o)
  );

  // checks
  `BMPT_ASSERT(a_peaks_ordered, out_valid_o |-> (peak_low_o <= peak_high_o))
  `BMPT_ASSERT(a_median_in_range, out_valid_o |-> (median_o <= peak_high_o && median_o >= peak_low_o))
  `BMPT_ASSERT(a_result_from_last, $rose(out_valid_o) |-> $past(accept && last))
  `BMPT_ASSERT_ALWAYS(a_fill_bound, !rst_ni || (fill_cnt_q < bmpt_pkg::cnt_t'(bmpt_pkg::Window)))

endmodule

@@ rtl/bmpt_sort_cell.sv @@
`timescale 1ns / 1ps

module bmpt_sort_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            occupied_i,
  input  bmpt_pkg::sample_t sample_i,
  input  bmpt_pkg::link_t left_i,
  output bmpt_pkg::link_t right_o,
  output bmpt_pkg::sample_t next_o
);

  bmpt_pkg::sample_t data_q;
  bmpt_pkg::sample_t data_d;
  logic              ins;

  // new sample belongs at or before this slot
  assign ins = !occupied_i || (sample_i < data_q);

  // take the new sample, shift from the left, or hold
  always_comb begin
    data_d = data_q;
    if (load_i) begin
      if (left_i.ins) begin
        data_d = left_i.data;
      end else if (ins) begin
        data_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign right_o.ins  = ins;
  assign right_o.data = data_q;
  assign next_o       = data_d;

endmodule

@@ rtl/bmpt_out_stage.sv @@
`timescale 1ns / 1ps

module bmpt_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              done_i,
  input  bmpt_pkg::sample_t median_i,
  input  logic              out_ready_i,
  output logic              space_o,
  output logic              out_valid_o,
  output bmpt_pkg::sample_t median_o,
  output bmpt_pkg::sample_t peak_high_o,
  output bmpt_pkg::sample_t peak_low_o
);

  logic              out_valid_q, out_valid_d;
  bmpt_pkg::sample_t median_q;
  bmpt_pkg::sample_t high_q, high_d;
  bmpt_pkg::sample_t low_q, low_d;

  // room for a new result when empty or draining this cycle
  assign space_o = !out_valid_q || out_ready_i;

  // result valid and running extremes
  always_comb begin
    out_valid_d = out_valid_q;
    high_d      = high_q;
    low_d       = low_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (done_i) begin
      out_valid_d = 1'b1;
      if (median_i > high_q) begin
        high_d = median_i;
      end
      if (median_i < low_q) begin
        low_d = median_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      high_q      <= '0;
      low_q       <= '1;
    end else begin
      out_valid_q <= out_valid_d;
      high_q      <= high_d;
      low_q       <= low_d;
    end
  end

  // median payload
  always_ff @(posedge clk_i) begin
    if (done_i) begin
      median_q <= median_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;
  assign peak_high_o = high_q;
  assign peak_low_o  = low_q;

endmodule
